/* rtl/pcw_pkg.sv */
// Shared types, constants and helpers for the PID controller block.
package pcw_pkg;

    localparam int ErrW    = 16;
    localparam int DtW     = 16;
    localparam int GainW   = 24;
    localparam int AlphaW  = 17;
    localparam int LimW    = 31;
    localparam int ThrW    = 11;
    localparam int DriveW  = 32;
    localparam int CfgW    = 31;
    localparam int IdxW    = 3;
    localparam int MulAW   = 48;
    localparam int MulBW   = 25;
    localparam int ProdW   = 64;
    localparam int DivNumW = 48;
    localparam int DivDenW = 20;
    localparam int DivRadixBits = 2;

    // integral step: (|x| >> 22) / 15625 by the reciprocal 2^47 / 15625 rounded up,
    // split as RcpHi * 2^24 + RcpLo; the operand is below 2^33
    localparam int RcpNW = 33;
    localparam logic [GainW-1:0] RcpLo = 24'd14611479;
    localparam logic [GainW-1:0] RcpHi = 24'd536;

    localparam logic [ThrW-1:0]    ThrottleGate = 11'd1060;
    localparam logic [AlphaW-1:0]  AlphaOne     = 17'd65536;
    localparam logic [DivDenW-1:0] UsPerSec     = 20'd1000000;

    typedef enum logic [IdxW-1:0] {
        REG_THROTTLE,
        REG_PGAIN,
        REG_IGAIN,
        REG_DGAIN,
        REG_ALPHA,
        REG_WINDUP,
        REG_OLIMIT,
        REG_CLEGG
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MUL_PG_E,
        MUL_IG_E,
        MUL_PROD_DT,
        MUL_DG_DIFF,
        MUL_PROD_MEGA,
        MUL_RCP_LO,
        MUL_RCP_HI,
        MUL_RAW_ALPHA,
        MUL_FD_BETA
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MP,
        ST_MI,
        ST_MT,
        ST_MD,
        ST_MU,
        ST_RL,
        ST_RH,
        ST_DI,
        ST_IN,
        ST_W2,
        ST_MA,
        ST_MB,
        ST_MC,
        ST_SUM,
        ST_CLR
    } pcw_state_t;

    typedef struct packed {
        logic     load;
        logic     clear;
        logic     finish;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        logic     cap_n;
        logic     cap_lo;
        logic     cap_p;
        logic     cap_di;
        logic     cap_integ;
        logic     cap_raw;
        logic     cap_fa;
        logic     cap_d;
    } pcw_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_kind;
        logic div_done;
        logic out_free;
    } pcw_stat_t;

    // signed divide by 2^16, truncating toward zero
    function automatic logic signed [ProdW-1:0] trunc_q16(input logic signed [ProdW-1:0] x);
        logic signed [ProdW-1:0] b;
        b = x + ((x < 0) ? 64'sd65535 : 64'sd0);
        return b >>> 16;
    endfunction

endpackage

/* rtl/pcw_if.sv */
// Valid/ready channel interfaces for sample words and result words.
interface pcw_in_if;
    import pcw_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [ErrW-1:0]   error_value;
    logic        [DtW-1:0]    step_time_us;

    modport source (output valid, kind, error_value, step_time_us, input ready);
    modport sink   (input valid, kind, error_value, step_time_us, output ready);
endinterface

interface pcw_out_if;
    import pcw_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DriveW-1:0] drive_value;
    logic                     integral_clamped;
    logic                     output_saturated;

    modport source (output valid, drive_value, integral_clamped, output_saturated, input ready);
    modport sink   (input valid, drive_value, integral_clamped, output_saturated, output ready);
endinterface

/* rtl/pcw_div.sv */
// Iterative unsigned divider, two quotient bits per cycle.
module pcw_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pcw_pkg::DivNumW-1:0]   num,
    input  logic [pcw_pkg::DivDenW-1:0]   den,
    output logic                          done,
    output logic [pcw_pkg::DivNumW-1:0]   quo
);
    import pcw_pkg::*;

    localparam int Steps = DivNumW / DivRadixBits;
    localparam int CntW  = $clog2(Steps + 1);

    logic [DivNumW-1:0] quo_reg, quo_next;
    logic [DivDenW-1:0] rem_reg, rem_next;
    logic [DivDenW-1:0] den_reg;
    logic [CntW-1:0]    cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DivDenW:0]   trial;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < DivRadixBits; i++)
        begin
            trial    = {rem_next, quo_next[DivNumW-1]};
            quo_next = {quo_next[DivNumW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = DivDenW'(trial - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DivDenW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(Steps);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/pcw_ctrl.sv */
// Sequencer for the PID datapath: multiplier and divider steps per sample.
module pcw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  pcw_pkg::pcw_stat_t stat,
    output pcw_pkg::pcw_cmd_t  cmd,
    output logic               in_ready
);
    import pcw_pkg::*;

    pcw_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_PG_E;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_kind ? ST_CLR : ST_MP;
                end
            end
            ST_MP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PG_E;
                state_next  = ST_MI;
            end
            ST_MI:
            begin
                cmd.cap_p   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_IG_E;
                state_next  = ST_MT;
            end
            ST_MT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROD_DT;
                state_next  = ST_MD;
            end
            ST_MD:
            begin
                cmd.cap_n   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DG_DIFF;
                state_next  = ST_MU;
            end
            ST_MU:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROD_MEGA;
                state_next  = ST_RL;
            end
            ST_RL:
            begin
                cmd.div_start = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_RCP_LO;
                state_next    = ST_RH;
            end
            ST_RH:
            begin
                cmd.cap_lo  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RCP_HI;
                state_next  = ST_DI;
            end
            ST_DI:
            begin
                cmd.cap_di = 1'b1;
                state_next = ST_IN;
            end
            ST_IN:
            begin
                cmd.cap_integ = 1'b1;
                state_next    = ST_W2;
            end
            ST_W2:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_raw = 1'b1;
                    state_next  = ST_MA;
                end
            end
            ST_MA:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RAW_ALPHA;
                state_next  = ST_MB;
            end
            ST_MB:
            begin
                cmd.cap_fa  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FD_BETA;
                state_next  = ST_MC;
            end
            ST_MC:
            begin
                cmd.cap_d  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                if (stat.out_free)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish || cmd.clear) |-> stat.out_free)
        else $error("result written while output slot busy");

    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg != ST_IDLE))
        else $error("sample word accepted but sequencer stayed idle");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_W2 && !stat.div_done) |=> (state_reg == ST_W2))
        else $error("left divider wait without done");

    a_start_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !stat.div_done)
        else $error("divider done right after start");

endmodule

/* rtl/pcw_dp.sv */
// PID datapath: config registers, shared multiplier, divider, state and output word.
module pcw_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pcw_pkg::IdxW-1:0]         cfg_index,
    input  logic [pcw_pkg::CfgW-1:0]         cfg_data,
    input  pcw_pkg::pcw_cmd_t                cmd,
    output pcw_pkg::pcw_stat_t               stat_dp,
    input  logic signed [pcw_pkg::ErrW-1:0]  in_error,
    input  logic [pcw_pkg::DtW-1:0]          in_dt,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic signed [pcw_pkg::DriveW-1:0] out_drive,
    output logic                             out_iclamp,
    output logic                             out_osat
);
    import pcw_pkg::*;

    // configuration
    logic [ThrW-1:0]   throttle_reg;
    logic [GainW-1:0]  pgain_reg;
    logic [GainW-1:0]  igain_reg;
    logic [GainW-1:0]  dgain_reg;
    logic [AlphaW-1:0] alpha_reg;
    logic [LimW-1:0]   windup_reg;
    logic [LimW-1:0]   olimit_reg;
    logic              clegg_reg;

    // controller state
    logic signed [ErrW-1:0]   last_err_reg;
    logic signed [DriveW-1:0] acc_reg;
    logic signed [DriveW-1:0] fd_reg;

    // per-sample working registers
    logic signed [ErrW-1:0]   e_reg;
    logic [DtW-1:0]           dt_reg;
    logic signed [ProdW-1:0]  prod_reg;
    logic signed [25:0]       p_reg;
    logic signed [25:0]       di_reg;
    logic signed [DriveW-1:0] integ_reg;
    logic                     iclamp_reg;
    logic signed [MulAW-1:0]  raw_reg;
    logic signed [ProdW-1:0]  fa_reg;
    logic signed [DriveW-1:0] d_reg;
    logic                     div_neg_reg;
    logic [RcpNW-1:0]         n_reg;
    logic                     n_neg_reg;
    logic [ProdW-1:0]         lo_reg;

    logic                     out_valid_reg;
    logic signed [DriveW-1:0] out_drive_reg;
    logic                     out_iclamp_reg;
    logic                     out_osat_reg;

    logic [AlphaW-1:0]        alpha_eff;
    logic [AlphaW-1:0]        beta;
    logic signed [ErrW:0]     diff;
    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [MulAW+MulBW-1:0] mul_full;
    logic [ProdW-1:0]         prod_abs;
    logic [DivDenW-1:0]       div_den;
    logic                     div_done;
    logic [DivNumW-1:0]       div_q;
    logic signed [DivNumW:0]  q_signed;
    logic signed [ProdW-1:0]  p_full;
    logic [ProdW-1:0]         rcp_sum;
    logic signed [25:0]       di_val;
    logic signed [33:0]       isum;
    logic signed [33:0]       wlim;
    logic signed [DriveW-1:0] integ_next;
    logic                     iclamp_next;
    logic                     sign_flip;
    logic signed [ProdW-1:0]  dsum;
    logic signed [ProdW-1:0]  dq;
    logic signed [DriveW-1:0] d_next;
    logic signed [33:0]       ysum;
    logic signed [33:0]       olim;
    logic signed [DriveW-1:0] y_next;
    logic                     osat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            throttle_reg <= 11'd1000;
            pgain_reg    <= '0;
            igain_reg    <= '0;
            dgain_reg    <= '0;
            alpha_reg    <= AlphaOne;
            windup_reg   <= '0;
            olimit_reg   <= '1;
            clegg_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_THROTTLE: throttle_reg <= cfg_data[ThrW-1:0];
                REG_PGAIN:    pgain_reg    <= cfg_data[GainW-1:0];
                REG_IGAIN:    igain_reg    <= cfg_data[GainW-1:0];
                REG_DGAIN:    dgain_reg    <= cfg_data[GainW-1:0];
                REG_ALPHA:    alpha_reg    <= cfg_data[AlphaW-1:0];
                REG_WINDUP:   windup_reg   <= cfg_data[LimW-1:0];
                REG_OLIMIT:   olimit_reg   <= cfg_data[LimW-1:0];
                REG_CLEGG:    clegg_reg    <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign alpha_eff = (alpha_reg > AlphaOne) ? AlphaOne : alpha_reg;
    assign beta      = AlphaOne - alpha_eff;
    assign diff      = (ErrW+1)'(e_reg) - (ErrW+1)'(last_err_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_PG_E:
            begin
                mul_a = MulAW'(e_reg);
                mul_b = {1'b0, pgain_reg};
            end
            MUL_IG_E:
            begin
                mul_a = MulAW'(e_reg);
                mul_b = {1'b0, igain_reg};
            end
            MUL_PROD_DT:
            begin
                mul_a = prod_reg[MulAW-1:0];
                mul_b = {{(MulBW-DtW){1'b0}}, dt_reg};
            end
            MUL_DG_DIFF:
            begin
                mul_a = MulAW'(diff);
                mul_b = {1'b0, dgain_reg};
            end
            MUL_PROD_MEGA:
            begin
                mul_a = prod_reg[MulAW-1:0];
                mul_b = {{(MulBW-DivDenW){1'b0}}, UsPerSec};
            end
            MUL_RCP_LO:
            begin
                mul_a = {{(MulAW-RcpNW){1'b0}}, n_reg};
                mul_b = {1'b0, RcpLo};
            end
            MUL_RCP_HI:
            begin
                mul_a = {{(MulAW-RcpNW){1'b0}}, n_reg};
                mul_b = {1'b0, RcpHi};
            end
            MUL_RAW_ALPHA:
            begin
                mul_a = raw_reg;
                mul_b = {{(MulBW-AlphaW){1'b0}}, alpha_eff};
            end
            MUL_FD_BETA:
            begin
                mul_a = MulAW'(fd_reg);
                mul_b = {{(MulBW-AlphaW){1'b0}}, beta};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // divider: |prod| / 2^16 by dt for the raw derivative
    assign prod_abs = (prod_reg < 0) ? ProdW'(-prod_reg) : ProdW'(prod_reg);
    assign div_den  = {{(DivDenW-DtW){1'b0}}, dt_reg};

    pcw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (prod_abs[ProdW-1:16]),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    assign q_signed = div_neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    assign p_full = trunc_q16(prod_reg);

    // integral step magnitude: (n*hi + ((n*lo) >> 24)) >> 23, hi product in prod_reg
    assign rcp_sum = $unsigned(prod_reg) + (lo_reg >> 24);
    assign di_val  = n_neg_reg ? -$signed({1'b0, rcp_sum[47:23]})
                               : $signed({1'b0, rcp_sum[47:23]});

    // integral with windup clamp, Clegg reset and throttle gate
    always_comb
    begin
        isum        = 34'(acc_reg) + 34'(di_reg);
        wlim        = $signed({3'b000, windup_reg});
        iclamp_next = 1'b0;
        if (isum > wlim)
        begin
            integ_next  = DriveW'(wlim);
            iclamp_next = 1'b1;
        end
        else if (isum < -wlim)
        begin
            integ_next  = DriveW'(-wlim);
            iclamp_next = 1'b1;
        end
        else
        begin
            integ_next = DriveW'(isum);
        end
        sign_flip = (last_err_reg < 0 && e_reg > 0) || (last_err_reg > 0 && e_reg < 0);
        if ((clegg_reg && sign_flip) || (throttle_reg < ThrottleGate))
            integ_next = '0;
    end

    // filtered derivative, saturated to 32 bits
    always_comb
    begin
        dsum = fa_reg + prod_reg;
        dq   = trunc_q16(dsum);
        if (dq > 64'sd2147483647)
            d_next = 32'sh7fffffff;
        else if (dq < -64'sd2147483648)
            d_next = 32'sh80000000;
        else
            d_next = dq[DriveW-1:0];
    end

    // output sum and clamp
    always_comb
    begin
        ysum      = 34'(p_reg) + 34'(integ_reg) + 34'(d_reg);
        olim      = $signed({3'b000, olimit_reg});
        osat_next = 1'b0;
        if (ysum > olim)
        begin
            y_next    = DriveW'(olim);
            osat_next = 1'b1;
        end
        else if (ysum < -olim)
        begin
            y_next    = DriveW'(-olim);
            osat_next = 1'b1;
        end
        else
        begin
            y_next = DriveW'(ysum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_reg  <= in_error;
            dt_reg <= (in_dt == '0) ? DtW'(1) : in_dt;
        end
        if (cmd.mul_en)
            prod_reg <= mul_full[ProdW-1:0];
        if (cmd.div_start)
            div_neg_reg <= (prod_reg < 0);
        if (cmd.cap_n)
        begin
            n_reg     <= prod_abs[RcpNW+21:22];
            n_neg_reg <= (prod_reg < 0);
        end
        if (cmd.cap_lo)
            lo_reg <= $unsigned(prod_reg);
        if (cmd.cap_p)
            p_reg <= p_full[25:0];
        if (cmd.cap_di)
            di_reg <= di_val;
        if (cmd.cap_integ)
        begin
            integ_reg  <= integ_next;
            iclamp_reg <= iclamp_next;
        end
        if (cmd.cap_raw)
            raw_reg <= q_signed[MulAW-1:0];
        if (cmd.cap_fa)
            fa_reg <= prod_reg;
        if (cmd.cap_d)
            d_reg <= d_next;
        if (cmd.finish)
        begin
            out_drive_reg  <= y_next;
            out_iclamp_reg <= iclamp_reg;
            out_osat_reg   <= osat_next;
        end
        else if (cmd.clear)
        begin
            out_drive_reg  <= '0;
            out_iclamp_reg <= 1'b0;
            out_osat_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg  <= '0;
            acc_reg       <= '0;
            fd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                last_err_reg <= e_reg;
                acc_reg      <= integ_reg;
                fd_reg       <= d_reg;
            end
            else if (cmd.clear)
            begin
                last_err_reg <= '0;
                acc_reg      <= '0;
                fd_reg       <= '0;
            end
            if (cmd.finish || cmd.clear)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat_dp.in_valid = 1'b0;
    assign stat_dp.in_kind  = 1'b0;
    assign stat_dp.div_done = div_done;
    assign stat_dp.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_drive  = out_drive_reg;
    assign out_iclamp = out_iclamp_reg;
    assign out_osat   = out_osat_reg;

endmodule

/* rtl/pid_controller_clegg_windup.sv */
// Top level of the PID controller with windup clamp and Clegg integrator reset.
// A control sample word goes from acceptance to the output register, once that
// register is free, through seven multiplier and sequencing steps up to the start of
// the derivative divide by dt, the two-bit-per-cycle divider pass (the integral step
// by 10^6 is a reciprocal multiply done inside it), then four steps for the filter and
// output sum; a clear word takes a single clear step. The next sample word is taken
// as soon as the result is in the output register, even while that result waits to
// be read. The user must write configuration through cfg_we, cfg_index and cfg_data
// only while no sample is in flight; the block itself does not enforce this.
module pid_controller_clegg_windup (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pcw_pkg::IdxW-1:0]   cfg_index,
    input  logic [pcw_pkg::CfgW-1:0]   cfg_data,
    pcw_in_if.sink                     sample,
    pcw_out_if.source                  result
);
    import pcw_pkg::*;

    pcw_cmd_t  cmd;
    pcw_stat_t stat_dp;
    pcw_stat_t stat;
    logic      in_ready;

    assign stat.in_valid = sample.valid;
    assign stat.in_kind  = sample.kind;
    assign stat.div_done = stat_dp.div_done;
    assign stat.out_free = stat_dp.out_free;

    assign sample.ready = in_ready;

    pcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    pcw_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat_dp    (stat_dp),
        .in_error   (sample.error_value),
        .in_dt      (sample.step_time_us),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .out_drive  (result.drive_value),
        .out_iclamp (result.integral_clamped),
        .out_osat   (result.output_saturated)
    );

endmodule
